/* hw/rtl/assert_macros.svh */
// Assertion macros used by the damage tracker core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* hw/rtl/drt_pkg.sv */
// Package: types, constants and mask helpers for the dirty-row damage tracker.
`default_nettype none
package drt_pkg;

    localparam int MAX_ROWS  = 256;
    localparam int WORD_BITS = 64;
    localparam int RC_W      = 9;                       // width of the rows-in-use field
    localparam int ROW_W     = 8;                       // width of row number fields
    localparam int TOT_OUT_W = 8;                       // width of reported scroll total
    localparam int ROWS_LIM  = (MAX_ROWS < 511) ? MAX_ROWS : 511;
    localparam logic [RC_W-1:0] ROWS_MAX = RC_W'(ROWS_LIM);
    localparam logic [RC_W-1:0] RC_RESET = RC_W'(24);

    typedef logic [MAX_ROWS-1:0] t_rows;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_MARK   = 3'd1,
        CMD_ALL    = 3'd2,
        CMD_SCROLL = 3'd3,
        CMD_QUERY  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [ROW_W-1:0] first_row;
        logic [ROW_W-1:0] last_row;
        logic [RC_W-1:0]  scroll_amount;
    } t_cmd_word;

    typedef struct packed {
        logic                 row_dirty;
        logic                 any_damage;
        logic                 full_redraw;
        logic                 scroll_pending;
        logic [TOT_OUT_W-1:0] scroll_total;
    } t_result;

    // Ones in rows 0..n-1; all ones once n reaches the row capacity.
    function automatic t_rows low_mask(input logic [RC_W-1:0] n);
        t_rows ones;
        ones = '1;
        return ~(ones << n);
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/drt_in_stage.sv */
// Input register: captures one command word per accepted start.
`default_nettype none
module drt_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire drt_pkg::t_cmd_word i_word,
    output logic                   o_vld,
    output drt_pkg::t_cmd_word     o_word
);
    import drt_pkg::*;

    logic      r_vld;
    t_cmd_word r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_accept;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_word <= i_word;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule
`default_nettype wire

/* hw/rtl/drt_core.sv */
// Tracker state, single-pass update logic and result register.
`default_nettype none
module drt_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [drt_pkg::RC_W-1:0] i_cfg_data,
    input  wire logic                   i_vld,
    input  wire drt_pkg::t_cmd_word     i_word,
    output logic [drt_pkg::RC_W-1:0]    o_rows_used,
    output logic                        o_done,
    output drt_pkg::t_result            o_res
);
    import drt_pkg::*;
    `include "assert_macros.svh"

    t_rows           r_bits,   n_bits;
    logic            r_full,   n_full;
    logic            r_scroll, n_scroll;
    logic [RC_W-1:0] r_total,  n_total;
    logic [RC_W-1:0] r_rc,     n_rc;
    logic            r_done;
    t_result         r_res,    n_res;

    logic [RC_W-1:0] first_ext, last_ext, last_clamp, keep, rc_cfg;
    logic [RC_W:0]   sum;
    t_rows           mark_mask, scroll_bits, rc_mask, keep_mask;
    logic            row_dirty;

    always_comb begin
        first_ext   = {1'b0, i_word.first_row};
        last_ext    = {1'b0, i_word.last_row};
        last_clamp  = (last_ext >= r_rc) ? (r_rc - 1'b1) : last_ext;
        mark_mask   = ~low_mask(first_ext) & low_mask(last_clamp + 1'b1);
        keep        = r_rc - i_word.scroll_amount;
        rc_mask     = low_mask(r_rc);
        keep_mask   = low_mask(keep);
        // shift surviving rows up, fill the rows that enter at the bottom
        scroll_bits = ((r_bits >> i_word.scroll_amount) & keep_mask)
                    | (rc_mask & ~keep_mask)
                    | (r_bits & ~rc_mask);
        sum         = {1'b0, r_total} + {1'b0, i_word.scroll_amount};
        rc_cfg      = (i_cfg_data > ROWS_MAX) ? ROWS_MAX : i_cfg_data;
    end

    always_comb begin
        n_bits    = r_bits;
        n_full    = r_full;
        n_scroll  = r_scroll;
        n_total   = r_total;
        n_rc      = r_rc;
        row_dirty = 1'b0;
        if (i_cfg_we) begin
            n_rc     = rc_cfg;
            n_bits   = '0;
            n_full   = 1'b1;
            n_scroll = 1'b0;
            n_total  = '0;
        end else if (i_vld) begin
            case (i_word.cmd)
                CMD_CLEAR: begin
                    n_bits   = '0;
                    n_full   = 1'b0;
                    n_scroll = 1'b0;
                    n_total  = '0;
                end
                CMD_MARK: begin
                    if (!r_full && (i_word.last_row >= i_word.first_row) && (r_rc != '0)) begin
                        n_bits = r_bits | mark_mask;
                    end
                end
                CMD_ALL: begin
                    n_full   = 1'b1;
                    n_scroll = 1'b0;
                    n_total  = '0;
                end
                CMD_SCROLL: begin
                    if ((i_word.scroll_amount != '0) && (r_rc != '0) && !r_full) begin
                        if (i_word.scroll_amount >= r_rc) begin
                            n_full   = 1'b1;
                            n_scroll = 1'b0;
                            n_total  = '0;
                        end else begin
                            n_bits = scroll_bits;
                            if (sum >= {1'b0, r_rc}) begin
                                n_full   = 1'b1;
                                n_scroll = 1'b0;
                                n_total  = '0;
                            end else begin
                                n_scroll = 1'b1;
                                n_total  = sum[RC_W-1:0];
                            end
                        end
                    end
                end
                CMD_QUERY: begin
                    row_dirty = (first_ext < r_rc) && (r_full || r_bits[i_word.first_row]);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_res.row_dirty      = row_dirty;
        n_res.any_damage     = n_full || n_scroll || (|n_bits);
        n_res.full_redraw    = n_full;
        n_res.scroll_pending = n_scroll;
        n_res.scroll_total   = n_total[TOT_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits   <= '0;
            r_full   <= 1'b1;
            r_scroll <= 1'b0;
            r_total  <= '0;
            r_rc     <= RC_RESET;
            r_done   <= 1'b0;
        end else begin
            r_bits   <= n_bits;
            r_full   <= n_full;
            r_scroll <= n_scroll;
            r_total  <= n_total;
            r_rc     <= n_rc;
            r_done   <= i_vld && !i_cfg_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_res <= n_res;
        end
    end

    assign o_rows_used = r_rc;
    assign o_done      = r_done;
    assign o_res       = r_res;

    `ASSERT_NEXT(a_cfg_forces_full, i_clk, i_rst_n, i_cfg_we, r_full && !r_scroll && (r_bits == '0), "resize did not force full redraw")
    `ASSERT_ALWAYS(a_rc_in_range, i_clk, i_rst_n, r_rc <= ROWS_MAX, "row count above capacity")
    `ASSERT_ALWAYS(a_total_below_rc, i_clk, i_rst_n, (r_total == '0) || (r_total < r_rc), "scroll total reached row count")
    `ASSERT_ALWAYS(a_full_excl_scroll, i_clk, i_rst_n, !(r_full && r_scroll), "full redraw with scroll pending")

endmodule
`default_nettype wire

/* hw/rtl/dirty_row_damage_tracker_top.sv */
// Top level: command port, APB register port and tracker pipeline.
// A result strobes on o_done after start is taken, through the input register
// and then the single-pass update into the result register.
// Throughput: one command per cycle, but a command that meets a rows-in-use write is dropped; busy is never raised.
// Reset (synchronous, active low): no dirty rows, full redraw set, no scroll,
// scroll total zero, row count 24. The receiver cannot stall results.
`default_nettype none
module dirty_row_damage_tracker_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [7:0]  i_first_row,
    input  wire logic [7:0]  i_last_row,
    input  wire logic [8:0]  i_scroll_amount,
    output logic             o_done,
    output logic             o_row_dirty,
    output logic             o_any_damage,
    output logic             o_full_redraw,
    output logic             o_scroll_pending,
    output logic [7:0]       o_scroll_total_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import drt_pkg::*;

    t_cmd_word       in_word, st_word;
    logic            st_vld;
    logic            cfg_we;
    logic [RC_W-1:0] rows_used;
    t_result         res;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    // the rows-in-use register is the only one, at every word address with paddr[2] clear
    assign cfg_we = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32-RC_W){1'b0}}, rows_used};

    assign in_word.cmd           = i_cmd;
    assign in_word.first_row     = i_first_row;
    assign in_word.last_row      = i_last_row;
    assign in_word.scroll_amount = i_scroll_amount;

    drt_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(start && !busy),
        .i_word  (in_word),
        .o_vld   (st_vld),
        .o_word  (st_word)
    );

    drt_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (pwdata[RC_W-1:0]),
        .i_vld      (st_vld),
        .i_word     (st_word),
        .o_rows_used(rows_used),
        .o_done     (o_done),
        .o_res      (res)
    );

    assign o_row_dirty        = res.row_dirty;
    assign o_any_damage       = res.any_damage;
    assign o_full_redraw      = res.full_redraw;
    assign o_scroll_pending   = res.scroll_pending;
    assign o_scroll_total_out = res.scroll_total;

endmodule
`default_nettype wire
